// ===== rtl/pms_pkg.sv =====
`timescale 1ns / 1ps

package pms_pkg;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd1;
    localparam logic [1:0] OP_STEP   = 2'd2;
    localparam logic [1:0] OP_RECOMP = 2'd3;

    localparam logic [1:0] CFG_SEQ_LENGTH    = 2'd0;
    localparam logic [1:0] CFG_ALPHABET_SIZE = 2'd1;

    localparam int DE_BITS = 17;

    typedef struct packed {
        logic capture;
        logic wr_first;
        logic wr_second;
        logic walk_init;
        logic walk_step;
        logic row_init;
        logic row_latch;
        logic col_step;
        logic exp_init;
        logic exp_step;
        logic finish;
    } pms_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       load_ok;
        logic       step_ok;
        logic       j_last;
        logic       row_done;
        logic       de_le0;
        logic       de_big;
        logic       mask_zero;
        logic       out_free;
    } pms_stat_t;

    // round(2^30 * exp(-2^(k-12)))
    function automatic logic [29:0] exp_coef(input logic [4:0] k);
        logic [29:0] c;
        case (k)
            5'd0:    c = 30'd1073479712;
            5'd1:    c = 30'd1073217664;
            5'd2:    c = 30'd1072693760;
            5'd3:    c = 30'd1071646719;
            5'd4:    c = 30'd1069555701;
            5'd5:    c = 30'd1065385899;
            5'd6:    c = 30'd1057095000;
            5'd7:    c = 30'd1040706261;
            5'd8:    c = 30'd1008687096;
            5'd9:    c = 30'd947573834;
            5'd10:   c = 30'd836230973;
            5'd11:   c = 30'd651257337;
            5'd12:   c = 30'd395007542;
            5'd13:   c = 30'd145315154;
            5'd14:   c = 30'd19666268;
            5'd15:   c = 30'd360200;
            5'd16:   c = 30'd121;
            default: c = 30'd0;
        endcase
        return c;
    endfunction

    function automatic logic [4:0] lowest_bit(input logic [DE_BITS-1:0] m);
        logic [4:0] k;
        k = 5'd0;
        for (int n = DE_BITS - 1; n >= 0; n--) begin
            if (m[n])
            begin
                k = 5'(n);
            end
        end
        return k;
    endfunction

endpackage

// ===== rtl/pms_ram.sv =====
`timescale 1ns / 1ps

module pms_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 262144
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ===== rtl/pms_ctrl.sv =====
`timescale 1ns / 1ps

module pms_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pms_pkg::pms_stat_t stat,
    output pms_pkg::pms_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DISP  = 4'd1;
    localparam logic [3:0] S_WR1   = 4'd2;
    localparam logic [3:0] S_WR2   = 4'd3;
    localparam logic [3:0] S_WALK  = 4'd4;
    localparam logic [3:0] S_DRAIN = 4'd5;
    localparam logic [3:0] S_EXPI  = 4'd6;
    localparam logic [3:0] S_EXPR  = 4'd7;
    localparam logic [3:0] S_ROW   = 4'd8;
    localparam logic [3:0] S_COL   = 4'd9;
    localparam logic [3:0] S_FIN   = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISP;
                end
            end
            S_DISP:
            begin
                case (stat.op)
                    pms_pkg::OP_LOAD:
                    begin
                        state_next = stat.load_ok ? S_WR1 : S_FIN;
                    end
                    pms_pkg::OP_STEP:
                    begin
                        if (stat.step_ok)
                        begin
                            cmd.walk_init = 1'b1;
                            state_next    = S_WALK;
                        end
                        else
                        begin
                            state_next = S_FIN;
                        end
                    end
                    pms_pkg::OP_RECOMP:
                    begin
                        cmd.row_init = 1'b1;
                        state_next   = S_ROW;
                    end
                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end
            S_WR1:
            begin
                cmd.wr_first = 1'b1;
                state_next   = S_WR2;
            end
            S_WR2:
            begin
                cmd.wr_second = 1'b1;
                state_next    = S_FIN;
            end
            S_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (stat.j_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_EXPI;
            end
            S_EXPI:
            begin
                cmd.exp_init = 1'b1;
                state_next   = (stat.de_le0 || stat.de_big) ? S_FIN : S_EXPR;
            end
            S_EXPR:
            begin
                if (stat.mask_zero)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.exp_step = 1'b1;
                end
            end
            S_ROW:
            begin
                if (stat.row_done)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.row_latch = 1'b1;
                    state_next    = S_COL;
                end
            end
            S_COL:
            begin
                cmd.col_step = 1'b1;
                if (stat.j_last)
                begin
                    state_next = S_ROW;
                end
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/pms_dp.sv =====
`timescale 1ns / 1ps

module pms_dp #(
    parameter int MAX_SITES   = 16,
    parameter int MAX_LETTERS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  pms_pkg::pms_cmd_t  cmd,
    output pms_pkg::pms_stat_t stat,
    input  logic               cfg_valid,
    input  logic [1:0]         cfg_index,
    input  logic [5:0]         cfg_data,
    input  logic [1:0]         op,
    input  logic [3:0]         site,
    input  logic [4:0]         residue,
    input  logic [3:0]         partner_site,
    input  logic [4:0]         partner_residue,
    input  logic signed [19:0] coupling_value,
    input  logic [23:0]        rand_u,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               accepted,
    output logic signed [31:0] energy,
    output logic [4:0]         old_residue
);

    localparam int SB        = $clog2(MAX_SITES);
    localparam int LB        = $clog2(MAX_LETTERS);
    localparam int CW        = (SB + 1 > 5) ? SB + 1 : 5;
    localparam int AW        = 2 * SB + 2 * LB;
    localparam int LEN_RST   = (MAX_SITES < 16) ? MAX_SITES : 16;
    localparam int ALPHA_RST = (MAX_LETTERS < 21) ? MAX_LETTERS : 21;

    // configuration
    logic [4:0] len_reg;
    logic [5:0] alpha_reg;
    logic [4:0] len_wr;
    logic [5:0] alpha_wr;

    always_comb
    begin
        if (cfg_data[4:0] < 5'd2)
        begin
            len_wr = 5'd2;
        end
        else if (32'(cfg_data[4:0]) > MAX_SITES)
        begin
            len_wr = 5'(MAX_SITES);
        end
        else
        begin
            len_wr = cfg_data[4:0];
        end
        if (cfg_data < 6'd2)
        begin
            alpha_wr = 6'd2;
        end
        else if (32'(cfg_data) > MAX_LETTERS)
        begin
            alpha_wr = 6'(MAX_LETTERS);
        end
        else
        begin
            alpha_wr = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= 5'(LEN_RST);
            alpha_reg <= 6'(ALPHA_RST);
        end
        else if (cfg_valid)
        begin
            if (cfg_index == pms_pkg::CFG_SEQ_LENGTH)
            begin
                len_reg <= len_wr;
            end
            else if (cfg_index == pms_pkg::CFG_ALPHABET_SIZE)
            begin
                alpha_reg <= alpha_wr;
            end
        end
    end

    // captured item
    logic [1:0]         op_reg;
    logic [3:0]         site_reg;
    logic [4:0]         res_reg;
    logic [3:0]         psite_reg;
    logic [4:0]         pres_reg;
    logic signed [19:0] cval_reg;
    logic [23:0]        u_reg;
    logic [4:0]         old_reg;

    // sequence store, single read mux
    logic [4:0]    seq_reg [MAX_SITES];
    logic [CW-1:0] seq_addr_w;
    logic [4:0]    seq_rd;
    logic          seq_we;

    logic [CW-1:0] j_reg;
    logic [CW-1:0] i_reg;
    logic [4:0]    si_reg;
    logic [CW-1:0] len_w;
    logic [CW-1:0] site_w;
    logic [CW-1:0] psite_w;
    logic [CW-1:0] in_site_w;

    assign len_w     = CW'(len_reg);
    assign site_w    = CW'(site_reg);
    assign psite_w   = CW'(psite_reg);
    assign in_site_w = CW'(site);

    always_comb
    begin
        if (cmd.capture)
        begin
            seq_addr_w = in_site_w;
        end
        else if (cmd.row_latch)
        begin
            seq_addr_w = i_reg;
        end
        else
        begin
            seq_addr_w = j_reg;
        end
    end

    assign seq_rd = seq_reg[seq_addr_w[SB-1:0]];

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= op;
            site_reg  <= site;
            res_reg   <= residue;
            psite_reg <= partner_site;
            pres_reg  <= partner_residue;
            cval_reg  <= coupling_value;
            u_reg     <= rand_u;
            old_reg   <= (in_site_w < CW'(MAX_SITES)) ? seq_rd : 5'd0;
        end
    end

    // index checks
    logic site_ok;
    logic res_ok;
    logic load_ok;

    assign site_ok = site_w < len_w;
    assign res_ok  = {1'b0, res_reg} < alpha_reg;
    assign load_ok = site_ok && res_ok && (psite_w < len_w) &&
                     ({1'b0, pres_reg} < alpha_reg) && (site_reg != psite_reg);

    // walk counters
    always_ff @(posedge clk)
    begin
        if (cmd.walk_init)
        begin
            j_reg <= '0;
        end
        else if (cmd.row_init)
        begin
            i_reg <= '0;
        end
        else if (cmd.row_latch)
        begin
            si_reg <= seq_rd;
            j_reg  <= i_reg + CW'(1);
        end
        else if (cmd.walk_step)
        begin
            j_reg <= j_reg + CW'(1);
        end
        else if (cmd.col_step)
        begin
            j_reg <= j_reg + CW'(1);
            if (j_reg == len_w - CW'(1))
            begin
                i_reg <= i_reg + CW'(1);
            end
        end
    end

    // coupling store
    logic [AW-1:0]      waddr;
    logic [AW-1:0]      raddr_a;
    logic [AW-1:0]      raddr_b;
    logic [19:0]        rdata_a;
    logic [19:0]        rdata_b;
    logic [CW-1:0]      row_sel;
    logic [4:0]         let_sel;

    assign waddr = cmd.wr_first ?
        {site_w[SB-1:0], psite_w[SB-1:0], res_reg[LB-1:0], pres_reg[LB-1:0]} :
        {psite_w[SB-1:0], site_w[SB-1:0], pres_reg[LB-1:0], res_reg[LB-1:0]};

    assign row_sel = (op_reg == pms_pkg::OP_RECOMP) ? i_reg : site_w;
    assign let_sel = (op_reg == pms_pkg::OP_RECOMP) ? si_reg : res_reg;
    assign raddr_a = {row_sel[SB-1:0], j_reg[SB-1:0], let_sel[LB-1:0], seq_rd[LB-1:0]};
    assign raddr_b = {site_w[SB-1:0], j_reg[SB-1:0], old_reg[LB-1:0], seq_rd[LB-1:0]};

    pms_ram #(
        .WIDTH (20),
        .DEPTH (1 << AW)
    ) u_coup (
        .clk     (clk),
        .we      (cmd.wr_first | cmd.wr_second),
        .waddr   (waddr),
        .wdata   (cval_reg),
        .raddr_a (raddr_a),
        .rdata_a (rdata_a),
        .raddr_b (raddr_b),
        .rdata_b (rdata_b)
    );

    // accumulate one read later
    logic               rd_v_reg;
    logic               rd_v_next;
    logic signed [31:0] acc_reg;
    logic signed [31:0] term;

    assign rd_v_next = (cmd.walk_step && (j_reg != site_w)) || cmd.col_step;
    assign term = (op_reg == pms_pkg::OP_RECOMP) ?
                  32'(signed'(rdata_a)) :
                  32'(signed'(rdata_a)) - 32'(signed'(rdata_b));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_v_reg <= 1'b0;
        end
        else
        begin
            rd_v_reg <= rd_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.walk_init || cmd.row_init || (cmd.capture))
        begin
            acc_reg <= '0;
        end
        else if (rd_v_reg)
        begin
            acc_reg <= acc_reg + term;
        end
    end

    // exp(-dE): one multiply per set bit of dE
    logic [pms_pkg::DE_BITS-1:0] mask_reg;
    logic [30:0]                 p_reg;
    logic [60:0]                 prod;
    logic [30:0]                 p_next;
    logic [31:0]                 p_round;
    logic                        de_le0;
    logic                        de_big;

    assign prod    = {30'd0, p_reg} * {31'd0, pms_pkg::exp_coef(pms_pkg::lowest_bit(mask_reg))};
    assign p_next  = 31'((prod + 61'd536870912) >> 30);
    assign p_round = {1'b0, p_reg} + 32'd32;
    assign de_le0  = acc_reg[31] || (acc_reg == '0);
    assign de_big  = !acc_reg[31] && (|acc_reg[30:pms_pkg::DE_BITS]);

    always_ff @(posedge clk)
    begin
        if (cmd.exp_init)
        begin
            mask_reg <= acc_reg[pms_pkg::DE_BITS-1:0];
            p_reg    <= 31'd1073741824;
        end
        else if (cmd.exp_step)
        begin
            mask_reg <= mask_reg & (mask_reg - 1'b1);
            p_reg    <= p_next;
        end
    end

    // result
    logic               move_ok;
    logic signed [31:0] energy_reg;
    logic signed [31:0] energy_next;
    logic signed [32:0] e_sum;
    logic               out_valid_reg;
    logic               acc_out_reg;
    logic signed [31:0] energy_out_reg;
    logic [4:0]         old_out_reg;

    assign move_ok = site_ok && res_ok &&
                     (de_le0 || (!de_big && (p_round[30:6] > {1'b0, u_reg})));
    assign e_sum   = {energy_reg[31], energy_reg} + {acc_reg[31], acc_reg};

    always_comb
    begin
        energy_next = energy_reg;
        if (op_reg == pms_pkg::OP_RECOMP)
        begin
            energy_next = acc_reg;
        end
        else if ((op_reg == pms_pkg::OP_STEP) && move_ok)
        begin
            if (e_sum[32] != e_sum[31])
            begin
                energy_next = e_sum[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
            end
            else
            begin
                energy_next = e_sum[31:0];
            end
        end
    end

    assign seq_we = cmd.finish &&
                    (((op_reg == pms_pkg::OP_WRITE) && site_ok && res_ok) ||
                     ((op_reg == pms_pkg::OP_STEP) && move_ok));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            energy_reg    <= '0;
            out_valid_reg <= 1'b0;
            for (int n = 0; n < MAX_SITES; n++)
            begin
                seq_reg[n] <= 5'd0;
            end
        end
        else
        begin
            if (cmd.finish)
            begin
                energy_reg    <= energy_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (seq_we)
            begin
                seq_reg[site_w[SB-1:0]] <= res_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            acc_out_reg    <= (op_reg == pms_pkg::OP_STEP) && move_ok;
            energy_out_reg <= energy_next;
            old_out_reg    <= old_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign accepted    = acc_out_reg;
    assign energy      = energy_out_reg;
    assign old_residue = old_out_reg;

    assign stat.op        = op_reg;
    assign stat.load_ok   = load_ok;
    assign stat.step_ok   = site_ok && res_ok;
    assign stat.j_last    = (j_reg == len_w - CW'(1));
    assign stat.row_done  = (i_reg >= len_w - CW'(1));
    assign stat.de_le0    = de_le0;
    assign stat.de_big    = de_big;
    assign stat.mask_zero = (mask_reg == '0);
    assign stat.out_free  = !out_valid_reg || out_ready;

endmodule

// ===== rtl/potts_metropolis_site_update.sv =====
// A load writes two RAM entries; a residue write or bad index goes straight to the
// result; a step walks the sites, then the exp unit unless dE <= 0 or dE >= 2^17; a
// recompute walks every site pair. Next item is taken after the result is registered;
// an output stall holds it back. Step time is set by the site walk (one coupling pair
// per cycle from a dual-read RAM) and the exp unit (one multiply per set bit of dE).
// Reset: control, sequence, energy and configuration to defaults; coupling RAM not cleared.
`timescale 1ns / 1ps

module potts_metropolis_site_update #(
    parameter int MAX_SITES   = 16,
    parameter int MAX_LETTERS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         op,
    input  logic [3:0]         site,
    input  logic [4:0]         residue,
    input  logic [3:0]         partner_site,
    input  logic [4:0]         partner_residue,
    input  logic signed [19:0] coupling_value,
    input  logic [23:0]        rand_u,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               accepted,
    output logic signed [31:0] energy,
    output logic [4:0]         old_residue,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [5:0]         cfg_data
);

    pms_pkg::pms_cmd_t  cmd;
    pms_pkg::pms_stat_t stat;

    assign cfg_ready = 1'b1;

    pms_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pms_dp #(
        .MAX_SITES   (MAX_SITES),
        .MAX_LETTERS (MAX_LETTERS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .op              (op),
        .site            (site),
        .residue         (residue),
        .partner_site    (partner_site),
        .partner_residue (partner_residue),
        .coupling_value  (coupling_value),
        .rand_u          (rand_u),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .accepted        (accepted),
        .energy          (energy),
        .old_residue     (old_residue)
    );

`ifndef SYNTHESIS
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(cmd))
        else $error("more than one datapath command");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("ready after transfer in");
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid)
        else $error("finished item without result");
`endif

endmodule
